// ===== rtl/dic_pkg.sv =====
// Shared types and constants of the dynamic inversion counter.
package dic_pkg;

  localparam int unsigned POS_W   = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned TOTAL_W = 20;
  localparam int unsigned COUNT_W = 19;
  localparam int unsigned WORD_W  = VALUE_W + 1;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] new_value;
  } dic_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] inversion_count;
    logic               position_error;
  } dic_out_t;

  typedef enum logic [2:0] {
    RAM_IDLE,
    RAM_CLEAR,
    RAM_RD_POS,
    RAM_RD_SCAN,
    RAM_WR_POS
  } ram_op_e;

  typedef struct packed {
    ram_op_e ram_op;
    logic    cnt_inc;
    logic    load;
    logic    out_load;
  } dic_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic pos_err;
  } dic_sts_t;

endpackage

// ===== rtl/dic_stream_if.sv =====
// Valid/ready channel carrying one payload word.
interface dic_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/dic_ram.sv =====
// Generic single-port RAM with registered read data.
module dic_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dic_ctrl.sv =====
// Sequencer for the clearing pass, the entry scan and result handoff.
module dic_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dic_pkg::dic_cmd_t cmd_o,
  input  dic_pkg::dic_sts_t sts_i
);
  import dic_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_RD_OLD = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_WRITE  = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.ram_op   = RAM_IDLE;
    in_ready_o     = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.ram_op  = RAM_CLEAR;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.pos_err ? ST_DONE : ST_RD_OLD;
        end
      end
      ST_RD_OLD: begin
        cmd_o.ram_op = RAM_RD_POS;
        state_d      = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.ram_op  = RAM_RD_SCAN;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.ram_op = RAM_WR_POS;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/dic_dpath.sv =====
// Entry store, scan comparators, running total and result register.
module dic_dpath #(
  parameter int unsigned MAX_ENTRIES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dic_pkg::dic_in_t  in_data_i,
  input  logic              cfg_valid_i,
  input  dic_pkg::len_t     cfg_data_i,
  input  dic_pkg::dic_cmd_t cmd_i,
  output dic_pkg::dic_sts_t sts_o,
  output dic_pkg::dic_out_t out_data_o
);
  import dic_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_ENTRIES - 1);

  len_t                      len_q;
  logic [IDX_W-1:0]          cnt_q;
  logic [IDX_W-1:0]          pos_q;
  logic signed [VALUE_W-1:0] key_q;
  logic                      err_q;
  logic                      old_mark_q;
  logic signed [VALUE_W-1:0] old_val_q;
  logic                      old_rd_q;
  logic                      scan_vld_q;
  logic [IDX_W-1:0]          scan_idx_q;
  logic [TOTAL_W-1:0]        total_q, total_d;
  dic_out_t                  out_q;

  logic                      ram_we, ram_re;
  logic [IDX_W-1:0]          ram_addr;
  logic [WORD_W-1:0]         ram_wdata, ram_rdata;

  logic                      ent_mark;
  logic signed [VALUE_W-1:0] ent_val;
  logic                      ent_before, ent_self;
  logic                      new_inv, old_inv;

  // A position at or beyond either the register or the store depth is rejected.
  assign sts_o.pos_err = ({1'b0, in_data_i.position} >= len_q) ||
                         (32'(in_data_i.position) >= 32'(MAX_ENTRIES));
  assign sts_o.cnt_last = (cnt_q == IDX_LAST);

  always_comb begin
    ram_we    = (cmd_i.ram_op == RAM_CLEAR) || (cmd_i.ram_op == RAM_WR_POS);
    ram_re    = (cmd_i.ram_op == RAM_RD_POS) || (cmd_i.ram_op == RAM_RD_SCAN);
    ram_addr  = ((cmd_i.ram_op == RAM_RD_POS) || (cmd_i.ram_op == RAM_WR_POS)) ? pos_q : cnt_q;
    ram_wdata = (cmd_i.ram_op == RAM_WR_POS) ? {1'b1, key_q} : '0;
  end

  dic_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Each scanned entry may drop one pair of the old value and add one of the new.
  always_comb begin
    ent_mark   = ram_rdata[WORD_W-1];
    ent_val    = $signed(ram_rdata[VALUE_W-1:0]);
    ent_before = (scan_idx_q < pos_q);
    ent_self   = (scan_idx_q == pos_q);
    new_inv    = scan_vld_q && ent_mark && !ent_self &&
                 (ent_before ? (ent_val > key_q) : (key_q > ent_val));
    old_inv    = scan_vld_q && ent_mark && !ent_self && old_mark_q &&
                 (ent_before ? (ent_val > old_val_q) : (old_val_q > ent_val));
    total_d    = total_q + TOTAL_W'(new_inv) - TOTAL_W'(old_inv);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= LEN_RESET;
      cnt_q      <= '0;
      total_q    <= '0;
      old_rd_q   <= 1'b0;
      scan_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        len_q <= cfg_data_i;
      end
      if (cmd_i.cnt_inc) begin
        cnt_q <= sts_o.cnt_last ? '0 : cnt_q + 1'b1;
      end
      if (scan_vld_q) begin
        total_q <= total_d;
      end
      old_rd_q   <= (cmd_i.ram_op == RAM_RD_POS);
      scan_vld_q <= (cmd_i.ram_op == RAM_RD_SCAN);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q <= IDX_W'(in_data_i.position);
      key_q <= in_data_i.new_value;
      err_q <= sts_o.pos_err;
    end
    if (old_rd_q) begin
      old_mark_q <= ram_rdata[WORD_W-1];
      old_val_q  <= $signed(ram_rdata[VALUE_W-1:0]);
    end
    scan_idx_q <= cnt_q;
    if (cmd_i.out_load) begin
      out_q.inversion_count <= total_q[COUNT_W-1:0];
      out_q.position_error  <= err_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/dynamic_inversion_counter.sv =====
// Top level of the dynamic inversion counter.
// Keeps MAX_ENTRIES signed entries and the running count of inversions among
// written entries; each request writes one position and returns the new total
// (low 19 bits) with an error flag for positions at or beyond active_length or
// MAX_ENTRIES. After reset the block clears its written marks in a pass over
// all MAX_ENTRIES entries before it takes the first request; configuration
// writes are taken throughout. A valid request scans every stored entry through
// one comparator pair on a single RAM port, one entry a cycle, before the next
// request is accepted; a rejected position skips the scan. A finished result
// waits in an output register while the next request is taken.
module dynamic_inversion_counter #(
  parameter int unsigned MAX_ENTRIES = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dic_stream_if.sink   cfg_i,
  dic_stream_if.sink   in_i,
  dic_stream_if.source out_o
);
  import dic_pkg::*;

  dic_cmd_t cmd;
  dic_sts_t sts;

  assign cfg_i.ready = 1'b1;

  dic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  dic_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_o.data)
  );

`ifndef SYNTHESIS
  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (in_i.valid && in_i.ready))
    else $error("item loaded without an accepted request");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request accepted while another is in work");

  a_scan_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts.cnt_last && cmd.ram_op == RAM_RD_SCAN) |=> (cmd.ram_op != RAM_RD_SCAN))
    else $error("scan ran past the last entry");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_o.valid || out_o.ready))
    else $error("pending result overwritten");
`endif

endmodule
